[design/mkdc_pkg.sv]
// Package for the matrix keypad debounce and click block.
// Holds matrix sizes, register indexes and the structs shared by the modules.
// No dependencies.
package mkdc_pkg;

  localparam int MAX_ROWS       = 4;
  localparam int MAX_COLS       = 4;
  localparam int NKEYS          = MAX_ROWS * MAX_COLS;
  localparam int KEY_BITS       = $clog2(NKEYS);
  localparam int CODE_BITS      = 8;
  localparam int CODE_WORD_BITS = 128;
  localparam int DIM_BITS       = 3;
  localparam int CNT_BITS       = 2 * DIM_BITS - 1;
  localparam int TIME_BITS      = 32;
  localparam int DEB_BITS       = 16;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 64;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_ROWS_IN_USE    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COLS_IN_USE    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DEBOUNCE_MS    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_KEY_CODES_LOW  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_KEY_CODES_HIGH = 3'd4;

  typedef logic [MAX_COLS-1:0][MAX_ROWS-1:0] scan_t;

  // per-key control from the top level
  typedef struct packed {
    logic step;
    logic in_use;
    logic clr;
  } key_ctl_t;

  typedef struct packed {
    logic                 valid;
    logic [KEY_BITS-1:0]  index;
    logic [CODE_BITS-1:0] code;
  } click_t;

endpackage

[design/mkdc_remap.sv]
// Maps one registered matrix scan onto raw key levels by key index.
// Also flags which keys are in use. Depends on mkdc_pkg.
module mkdc_remap
  import mkdc_pkg::*;
(
  input  scan_t                scan,
  input  logic [DIM_BITS-1:0]  rows_in_use,
  input  logic [DIM_BITS-1:0]  cols_in_use,
  output logic [NKEYS-1:0]     raw,
  output logic [NKEYS-1:0]     in_use
);

  logic [DIM_BITS-1:0] rows_c;
  logic [DIM_BITS-1:0] cols_c;
  logic [CNT_BITS-1:0] total;

  assign rows_c = (rows_in_use > DIM_BITS'(MAX_ROWS)) ? DIM_BITS'(MAX_ROWS) : rows_in_use;
  assign cols_c = (cols_in_use > DIM_BITS'(MAX_COLS)) ? DIM_BITS'(MAX_COLS) : cols_in_use;
  assign total  = CNT_BITS'(rows_c) * CNT_BITS'(cols_c);

  // scatter each wired cell to index row * cols + col
  always_comb begin
    logic [CNT_BITS-1:0] idx;
    raw = '0;
    for (int r = 0; r < MAX_ROWS; r++) begin
      for (int c = 0; c < MAX_COLS; c++) begin
        idx = CNT_BITS'(r) * CNT_BITS'(cols_c) + CNT_BITS'(c);
        if ((DIM_BITS'(r) < rows_c) && (DIM_BITS'(c) < cols_c) &&
            (idx < CNT_BITS'(NKEYS))) begin
          raw[idx[KEY_BITS-1:0]] = scan[c][r];
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NKEYS; k++) begin
      in_use[k] = CNT_BITS'(k) < total;
    end
  end

endmodule

[design/mkdc_key.sv]
// Debounce and click cell for one key: candidate tracking with a time stamp,
// stable level, press state and pending click. Depends on mkdc_pkg.
module mkdc_key
  import mkdc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  key_ctl_t             ctl,
  input  logic                 raw,
  input  logic [TIME_BITS-1:0] now_ms,
  input  logic [DEB_BITS-1:0]  debounce_ms,
  output logic                 pending
);

  logic                 stable_r, stable_nxt;
  logic                 press_r, press_nxt;
  logic                 run_r, run_nxt;
  logic                 cand_r, cand_nxt;
  logic [TIME_BITS-1:0] ctime_r, ctime_nxt;
  logic                 pend_r, pend_upd;
  logic [TIME_BITS-1:0] elapsed;
  logic                 en;

  assign en      = ctl.step & ctl.in_use;
  assign elapsed = now_ms - ctime_r;

  always_comb begin
    run_nxt    = run_r;
    cand_nxt   = cand_r;
    ctime_nxt  = ctime_r;
    stable_nxt = stable_r;
    if (!run_r) begin
      if (raw != stable_r) begin
        run_nxt   = 1'b1;
        cand_nxt  = raw;
        ctime_nxt = now_ms;
      end
    end else if (raw == stable_r) begin
      run_nxt = 1'b0;
    end else if (raw != cand_r) begin
      // restart the candidate at the new level
      cand_nxt  = raw;
      ctime_nxt = now_ms;
    end else if (elapsed >= TIME_BITS'(debounce_ms)) begin
      run_nxt    = 1'b0;
      stable_nxt = cand_r;
    end
  end

  always_comb begin
    press_nxt = press_r;
    pend_upd  = pend_r;
    if (stable_nxt != stable_r) begin
      if (stable_nxt) begin
        press_nxt = 1'b1;
      end else if (press_r) begin
        pend_upd  = 1'b1;
        press_nxt = 1'b0;
      end
    end
  end

  // frozen keys show their held click
  assign pending = en ? pend_upd : pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r <= 1'b0;
      press_r  <= 1'b0;
      run_r    <= 1'b0;
      cand_r   <= 1'b0;
      pend_r   <= 1'b0;
    end else begin
      if (en) begin
        stable_r <= stable_nxt;
        press_r  <= press_nxt;
        run_r    <= run_nxt;
        cand_r   <= cand_nxt;
      end
      if (ctl.step) begin
        pend_r <= pending & ~ctl.clr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctime_r <= '0;
    end else if (en) begin
      ctime_r <= ctime_nxt;
    end
  end

endmodule

[design/mkdc_pick.sv]
// Picks the lowest-index pending click among keys in use and looks up its code.
// Depends on mkdc_pkg.
module mkdc_pick
  import mkdc_pkg::*;
(
  input  logic [NKEYS-1:0]          pending,
  input  logic [NKEYS-1:0]          in_use,
  input  logic [CODE_WORD_BITS-1:0] codes,
  output click_t                    click,
  output logic [NKEYS-1:0]          clr
);

  logic [NKEYS-1:0]    cand;
  logic                found;
  logic [KEY_BITS-1:0] idx;

  assign cand = pending & in_use;

  // walk down so the lowest set index wins
  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int k = NKEYS - 1; k >= 0; k--) begin
      if (cand[k]) begin
        found = 1'b1;
        idx   = KEY_BITS'(k);
      end
    end
  end

  always_comb begin
    clr         = '0;
    click.valid = found;
    click.index = '0;
    click.code  = '0;
    if (found) begin
      clr[idx]    = 1'b1;
      click.index = idx;
      click.code  = codes[idx * CODE_BITS +: CODE_BITS];
    end
  end

endmodule

[design/matrix_keypad_debounce_click.sv]
// Top level of the matrix keypad debounce and click block.
// Uses mkdc_pkg, mkdc_remap, mkdc_key and mkdc_pick.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------------------------
//   in      | to block  | in_valid/in_ready   | in_rows_col0..3, in_now_ms
//   out     | from block| out_valid/out_ready | out_click_valid, out_click_index, out_click_code
//   cfg     | to block  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One scan per cycle unless the result stalls: a scan is registered, then the per-key
// debounce cells and the click picker update state and load the result register.
// The result is presented from the result register; cfg_ready is always high.
// A stalled result holds the scan register; in_ready drops only when both are full
// and out_ready is low.
// Synchronous reset clears all key state and loads the register defaults.
module matrix_keypad_debounce_click
  import mkdc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [MAX_ROWS-1:0]       in_rows_col0,
  input  logic [MAX_ROWS-1:0]       in_rows_col1,
  input  logic [MAX_ROWS-1:0]       in_rows_col2,
  input  logic [MAX_ROWS-1:0]       in_rows_col3,
  input  logic [TIME_BITS-1:0]      in_now_ms,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_click_valid,
  output logic [KEY_BITS-1:0]       out_click_index,
  output logic [CODE_BITS-1:0]      out_click_code,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  logic [DIM_BITS-1:0]      rows_r;
  logic [DIM_BITS-1:0]      cols_r;
  logic [DEB_BITS-1:0]      deb_r;
  logic [CFG_DATA_BITS-1:0] codes_lo_r;
  logic [CFG_DATA_BITS-1:0] codes_hi_r;

  logic                 s1_valid_r;
  scan_t                s1_scan_r;
  logic [TIME_BITS-1:0] s1_now_r;
  logic                 out_valid_r;
  click_t               out_click_r;

  logic             step;
  logic             in_fire;
  logic [NKEYS-1:0] raw;
  logic [NKEYS-1:0] in_use;
  logic [NKEYS-1:0] pending;
  logic [NKEYS-1:0] clr;
  click_t           click;

  assign cfg_ready = 1'b1;
  assign step      = s1_valid_r & (~out_valid_r | out_ready);
  assign in_ready  = ~s1_valid_r | step;
  assign in_fire   = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r     <= DIM_BITS'(MAX_ROWS);
      cols_r     <= DIM_BITS'(MAX_COLS);
      deb_r      <= DEB_BITS'(20);
      codes_lo_r <= '0;
      codes_hi_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ROWS_IN_USE:    rows_r     <= cfg_data[DIM_BITS-1:0];
        CFG_COLS_IN_USE:    cols_r     <= cfg_data[DIM_BITS-1:0];
        CFG_DEBOUNCE_MS:    deb_r      <= cfg_data[DEB_BITS-1:0];
        CFG_KEY_CODES_LOW:  codes_lo_r <= cfg_data;
        CFG_KEY_CODES_HIGH: codes_hi_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // scan register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_scan_r <= {in_rows_col3, in_rows_col2, in_rows_col1, in_rows_col0};
      s1_now_r  <= in_now_ms;
    end
  end

  mkdc_remap u_remap (
    .scan        (s1_scan_r),
    .rows_in_use (rows_r),
    .cols_in_use (cols_r),
    .raw         (raw),
    .in_use      (in_use)
  );

  for (genvar k = 0; k < NKEYS; k++) begin : g_key
    key_ctl_t ctl;
    assign ctl = '{step: step, in_use: in_use[k], clr: clr[k]};

    mkdc_key u_key (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .raw         (raw[k]),
      .now_ms      (s1_now_r),
      .debounce_ms (deb_r),
      .pending     (pending[k])
    );
  end

  mkdc_pick u_pick (
    .pending (pending),
    .in_use  (in_use),
    .codes   ({codes_hi_r, codes_lo_r}),
    .click   (click),
    .clr     (clr)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_click_r <= click;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_click_valid = out_click_r.valid;
  assign out_click_index = out_click_r.index;
  assign out_click_code  = out_click_r.code;

  a_step_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("result register not loaded after a step");

  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ready) |-> !in_ready)
    else $error("input taken while both stages are full");

  a_one_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(clr) && ((clr != '0) == click.valid))
    else $error("click clear does not match the reported click");

  a_clear_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    (clr & ~in_use) == '0)
    else $error("click cleared on a key not in use");

  a_idle_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_click_r.valid) |->
      (out_click_r.index == '0 && out_click_r.code == '0))
    else $error("empty result carries a nonzero index or code");

endmodule

[bench/testbench.sv]
// Testbench for matrix_keypad_debounce_click: random and directed keypad scans,
// checked against an in-bench debounce and click predictor.
// Depends on mkdc_pkg and the design top level only.
module testbench;
  import mkdc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 500_000;
  localparam int LONG_HOLD = 120;

  typedef struct packed {
    scan_t                mask;
    logic [TIME_BITS-1:0] now;
  } scan_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [MAX_ROWS-1:0] in_rows_col0 = '0;
  logic [MAX_ROWS-1:0] in_rows_col1 = '0;
  logic [MAX_ROWS-1:0] in_rows_col2 = '0;
  logic [MAX_ROWS-1:0] in_rows_col3 = '0;
  logic [TIME_BITS-1:0] in_now_ms = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_click_valid;
  logic [KEY_BITS-1:0] out_click_index;
  logic [CODE_BITS-1:0] out_click_code;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  matrix_keypad_debounce_click uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_rows_col0(in_rows_col0), .in_rows_col1(in_rows_col1),
    .in_rows_col2(in_rows_col2), .in_rows_col3(in_rows_col3),
    .in_now_ms(in_now_ms),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_click_valid(out_click_valid), .out_click_index(out_click_index),
    .out_click_code(out_click_code),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor copy of the registers and per-key state
  logic [DIM_BITS-1:0]       use_rows = 3'd4;
  logic [DIM_BITS-1:0]       use_cols = 3'd4;
  logic [DEB_BITS-1:0]       settle_ms = 16'd20;
  logic [CODE_WORD_BITS-1:0] code_word = '0;
  logic [NKEYS-1:0]          key_stable = '0;
  logic [NKEYS-1:0]          key_pressed = '0;
  logic [NKEYS-1:0]          key_settling = '0;
  logic [NKEYS-1:0]          key_cand_level = '0;
  logic [TIME_BITS-1:0]      key_cand_ms [NKEYS] = '{default: '0};
  logic [NKEYS-1:0]          key_click_pending = '0;

  scan_item_t scan_q[$];
  click_t     click_expect_q[$];

  int unsigned scans_queued = 0;
  int unsigned results_checked = 0;
  int unsigned clicks_seen = 0;
  int unsigned settings_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  bit idle_on = 1'b1;
  int unsigned hold_req = 0;

  // stimulus generator state: physical key positions, chatter, time
  logic [NKEYS-1:0]     finger = '0;
  int                   chatter_left [NKEYS] = '{default: 0};
  logic [TIME_BITS-1:0] sim_ms = '0;

  function automatic void load_reg(logic [CFG_IDX_BITS-1:0] idx, logic [63:0] val);
    case (idx)
      CFG_ROWS_IN_USE:    use_rows = val[DIM_BITS-1:0];
      CFG_COLS_IN_USE:    use_cols = val[DIM_BITS-1:0];
      CFG_DEBOUNCE_MS:    settle_ms = val[DEB_BITS-1:0];
      CFG_KEY_CODES_LOW:  code_word[63:0] = val;
      CFG_KEY_CODES_HIGH: code_word[127:64] = val;
      default: ;
    endcase
  endfunction

  function automatic click_t predict_click(scan_item_t it);
    int rows;
    int cols;
    int total;
    logic [NKEYS-1:0] raw;
    logic was;
    logic [TIME_BITS-1:0] age;
    click_t res;
    rows = (use_rows > MAX_ROWS) ? MAX_ROWS : int'(use_rows);
    cols = (use_cols > MAX_COLS) ? MAX_COLS : int'(use_cols);
    total = rows * cols;
    raw = '0;
    for (int c = 0; c < cols; c++)
      for (int r = 0; r < rows; r++)
        raw[r * cols + c] = it.mask[c][r];
    for (int k = 0; k < total; k++) begin
      was = key_stable[k];
      age = it.now - key_cand_ms[k];
      if (!key_settling[k]) begin
        if (raw[k] != was) begin
          key_settling[k] = 1'b1;
          key_cand_level[k] = raw[k];
          key_cand_ms[k] = it.now;
        end
      end else if (raw[k] == was) begin
        key_settling[k] = 1'b0;
      end else if (raw[k] != key_cand_level[k]) begin
        key_cand_level[k] = raw[k];
        key_cand_ms[k] = it.now;
      end else if (age >= TIME_BITS'(settle_ms)) begin
        key_settling[k] = 1'b0;
        key_stable[k] = key_cand_level[k];
      end
      if (key_stable[k] != was) begin
        if (key_stable[k]) begin
          key_pressed[k] = 1'b1;
        end else if (key_pressed[k]) begin
          key_click_pending[k] = 1'b1;
          key_pressed[k] = 1'b0;
        end
      end
    end
    res = '0;
    for (int k = 0; k < total; k++) begin
      if (key_click_pending[k]) begin
        key_click_pending[k] = 1'b0;
        res.valid = 1'b1;
        res.index = KEY_BITS'(k);
        res.code = code_word[k * CODE_BITS +: CODE_BITS];
        break;
      end
    end
    return res;
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    $display("mismatch in %s: got %0d, expected %0d (result %0d)",
             what, got, want, results_checked);
    mismatch_count++;
  endtask

  // sender: present the next scan once the current one is taken
  always @(posedge clk) begin
    scan_item_t cur;
    int gap_left;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready)
        click_expect_q.push_back(predict_click(cur));
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (scan_q.size() > 0) begin
          cur = scan_q.pop_front();
          in_rows_col0 <= cur.mask[0];
          in_rows_col1 <= cur.mask[1];
          in_rows_col2 <= cur.mask[2];
          in_rows_col3 <= cur.mask[3];
          in_now_ms <= cur.now;
          in_valid <= 1'b1;
          if (idle_on && $urandom_range(0, 7) == 0)
            gap_left = $urandom_range(1, 16);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls plus one long hold on request
  always @(posedge clk) begin
    int stall_left;
    int unsigned hold_ack;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
      hold_ack = 0;
    end else if (hold_ack != hold_req) begin
      hold_ack = hold_req;
      stall_left = LONG_HOLD;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 16) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    click_t want;
    if (rst_n && out_valid && out_ready) begin
      if (click_expect_q.size() == 0) begin
        flag_mismatch("unexpected result index", int'(out_click_index), 0);
      end else begin
        want = click_expect_q.pop_front();
        if (out_click_valid !== want.valid)
          flag_mismatch("click_valid", int'(out_click_valid), int'(want.valid));
        if (out_click_index !== want.index)
          flag_mismatch("click_index", int'(out_click_index), int'(want.index));
        if (out_click_code !== want.code)
          flag_mismatch("click_code", int'(out_click_code), int'(want.code));
        if (want.valid)
          clicks_seen++;
      end
      results_checked++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic add_scan(logic [NKEYS-1:0] m, logic [TIME_BITS-1:0] t);
    scan_item_t s;
    s.mask = m;
    s.now = t;
    scan_q.push_back(s);
    scans_queued++;
  endtask

  // hold valid across back-to-back writes; caller drops it afterwards
  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    load_reg(idx, val);
  endtask

  task automatic configure(int rows, int cols, int deb, logic [63:0] lo, logic [63:0] hi);
    write_reg(CFG_ROWS_IN_USE, ({$urandom(), $urandom()} << DIM_BITS) | 64'(rows));
    write_reg(CFG_COLS_IN_USE, ({$urandom(), $urandom()} << DIM_BITS) | 64'(cols));
    write_reg(CFG_DEBOUNCE_MS, ({$urandom(), $urandom()} << DEB_BITS) | 64'(deb));
    write_reg(CFG_KEY_CODES_LOW, lo);
    write_reg(CFG_KEY_CODES_HIGH, hi);
    cfg_valid <= 1'b0;
    settings_count++;
  endtask

  task automatic wait_drained();
    while (results_checked < scans_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // well-formed presses with chatter, mixed with pure noise scans
  task automatic gen_scans(int n, int noise_pct, int step_max);
    logic [NKEYS-1:0] raw;
    for (int i = 0; i < n; i++) begin
      sim_ms += TIME_BITS'($urandom_range(0, step_max));
      if ($urandom_range(0, 99) < noise_pct) begin
        add_scan(NKEYS'($urandom()), $urandom());
      end else begin
        for (int p = 0; p < NKEYS; p++) begin
          if ($urandom_range(0, 47) == 0) begin
            finger[p] = ~finger[p];
            chatter_left[p] = $urandom_range(0, 4);
          end
        end
        raw = finger;
        for (int p = 0; p < NKEYS; p++) begin
          if (chatter_left[p] > 0) begin
            raw[p] = 1'($urandom_range(0, 1));
            chatter_left[p]--;
          end
        end
        add_scan(raw, sim_ms);
      end
    end
  endtask

  initial begin
    int rows;
    int cols;
    int deb;
    int noise;
    int n;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // all keys pressed and released across the time wrap, one chatter cancel
    configure(4, 4, 20, 64'h8877_6655_4433_2211, 64'h00FF_EEDD_CCBB_AA99);
    add_scan(16'h0000, 32'h0000_0000);
    add_scan(16'hFFFF, 32'hFFFF_FFF0);
    add_scan(16'hFFFF, 32'hFFFF_FFF8);
    add_scan(16'hFFFF, 32'h0000_0004);
    add_scan(16'h0000, 32'h0000_0010);
    add_scan(16'hFFFF, 32'h0000_0012);
    add_scan(16'h0000, 32'h0000_0014);
    add_scan(16'h0000, 32'h0000_0028);
    add_scan(16'h0000, 32'h0000_0029);
    wait_drained();
    // one key in use, zero debounce; the other pending clicks stay frozen
    configure(1, 1, 0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0123_4567_89AB_CDEF);
    add_scan(16'h0000, 32'h0000_0030);
    add_scan(16'h0001, 32'h0000_0030);
    add_scan(16'h0001, 32'h0000_0030);
    add_scan(16'h0000, 32'h0000_0031);
    add_scan(16'h0000, 32'h0000_0031);
    wait_drained();
    configure(0, 1, 0, 64'h0, 64'h0);
    add_scan(16'hFFFF, 32'h0000_0040);
    wait_drained();
    // oversized dimensions clamp to the full matrix; frozen clicks start to drain
    configure(7, 5, 65535, {$urandom(), $urandom()}, {$urandom(), $urandom()});
    for (int i = 0; i < 8; i++)
      add_scan(NKEYS'($urandom()), 32'h0000_0050 + i);
    wait_drained();

    for (int ph = 0; ph < 14; ph++) begin
      rows = $urandom_range(1, MAX_ROWS);
      cols = $urandom_range(1, MAX_COLS);
      deb = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 40) : $urandom_range(0, 65535);
      noise = $urandom_range(0, 15);
      n = 130;
      idle_on = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 3) == 0)
        sim_ms = $urandom();
      case (ph)
        0: begin rows = 4; cols = 4; deb = 0; end
        1: begin
          rows = 4;
          cols = 4;
          deb = 65535;
          sim_ms = 32'hFFFF_FFFF - $urandom_range(0, 100000);
        end
        2: begin rows = 1; cols = MAX_COLS; deb = 1; end
        3: begin rows = MAX_ROWS; cols = 1; end
        4: begin rows = 0; n = 20; end
        5: begin rows = 7; cols = 6; end
        6: noise = 100;
        8: idle_on = 1'b0;
        13: idle_on = 1'b0;
        default: ;
      endcase
      configure(rows, cols, deb, {$urandom(), $urandom()}, {$urandom(), $urandom()});
      if (ph == 8)
        hold_req <= hold_req + 1;
      if (ph == 9) begin
        // pause the sender mid-setting until every result is back
        gen_scans(n / 2, noise, deb / 6 + 2);
        wait_drained();
        gen_scans(n - n / 2, noise, deb / 6 + 2);
      end else begin
        gen_scans(n, noise, deb / 6 + 2);
      end
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (click_expect_q.size() != 0)
      flag_mismatch("results never delivered", 0, click_expect_q.size());
    $display("Ran %0d scans over %0d register settings; %0d clicks were reported.",
             scans_queued, settings_count, clicks_seen);
    $display("Covered chatter, time wrap, zero and maximum debounce, clamped and unused keys.");
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[files.f]
design/mkdc_pkg.sv
design/mkdc_remap.sv
design/mkdc_key.sv
design/mkdc_pick.sv
design/matrix_keypad_debounce_click.sv
bench/testbench.sv
